/* src/lshist_pkg.sv */
`timescale 1ns / 1ps

package lshist_pkg;

    // Default sizing
    localparam int NUM_STAGES_DEF  = 8;
    localparam int NUM_BUCKETS_DEF = 64;

    // Fixed field widths
    localparam int OP_W    = 2;
    localparam int STAGE_W = 3;
    localparam int NS_W    = 64;
    localparam int BKT_W   = 6;
    localparam int CNT_W   = 64;
    localparam int STAT_W  = 3 * CNT_W;

    // Operation codes
    localparam logic [OP_W-1:0] OP_RECORD = 2'd0;
    localparam logic [OP_W-1:0] OP_READ   = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

    // Controller states
    typedef enum logic [1:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_ISSUE,
        ST_UPDATE
    } lshist_state_t;

    // One stage entry of the statistics memory
    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic [CNT_W-1:0] total;
        logic [CNT_W-1:0] max;
    } lshist_stat_t;

    // Index of the highest set bit; 0 for values 0 and 1
    function automatic logic [BKT_W-1:0] msb_index(input logic [NS_W-1:0] v);
        logic [BKT_W-1:0] idx;
        idx = '0;
        for (int i = 0; i < NS_W; i++) begin
            if (v[i])
            begin
                idx = BKT_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

/* src/lshist_in_if.sv */
`timescale 1ns / 1ps

interface lshist_in_if;
    import lshist_pkg::*;

    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    op;
    logic [STAGE_W-1:0] stage;
    logic [NS_W-1:0]    elapsed_ns;
    logic [BKT_W-1:0]   bucket_index;

    modport source (output valid, output op, output stage, output elapsed_ns,
                    output bucket_index, input ready);
    modport sink   (input valid, input op, input stage, input elapsed_ns,
                    input bucket_index, output ready);
endinterface

/* src/lshist_out_if.sv */
`timescale 1ns / 1ps

interface lshist_out_if;
    import lshist_pkg::*;

    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] sample_count;
    logic [CNT_W-1:0] duration_total;
    logic [CNT_W-1:0] duration_max;
    logic [CNT_W-1:0] bucket_hits;

    modport source (output valid, output sample_count, output duration_total,
                    output duration_max, output bucket_hits, input ready);
    modport sink   (input valid, input sample_count, input duration_total,
                    input duration_max, input bucket_hits, output ready);
endinterface

/* src/latency_stats_log2_histogram.sv */
`timescale 1ns / 1ps

// Per-stage latency statistics: count, total, maximum and a log2 histogram
// for each of NUM_STAGES stages, held in two single-port-write memories
// (one stage entry of count/total/max, one histogram counter per stage and
// bucket). A record word reads both entries and writes them back (accept,
// memory read, write back, then ready again). A read word takes the same
// steps and loads the output register; a further read waits only if the
// previous result has not been taken. An unused op code, or an ignored
// record, leaves the block ready in the next cycle. A clear word and reset
// both start a clearing pass over NUM_STAGES * 2**clog2(NUM_BUCKETS)
// histogram entries (512 at the defaults), one write per cycle, during which
// no word is accepted; the enable register can be written at any time.
module latency_stats_log2_histogram #(
    parameter int NUM_STAGES  = lshist_pkg::NUM_STAGES_DEF,
    parameter int NUM_BUCKETS = lshist_pkg::NUM_BUCKETS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_wr_en,
    input  logic          cfg_wr_data,
    lshist_in_if.sink     in_ch,
    lshist_out_if.source  out_ch
);
    import lshist_pkg::*;

    localparam int STAGE_AW   = (NUM_STAGES > 1) ? $clog2(NUM_STAGES) : 1;
    localparam int BKT_AW     = $clog2(NUM_BUCKETS);
    localparam int HIST_DEPTH = NUM_STAGES * (1 << BKT_AW);
    localparam int HIST_AW    = $clog2(HIST_DEPTH);

    logic                enable_reg;

    logic                stat_we;
    logic [STAGE_AW-1:0] stat_waddr;
    logic [STAT_W-1:0]   stat_wdata;
    logic                stat_re;
    logic [STAGE_AW-1:0] stat_raddr;
    logic [STAT_W-1:0]   stat_rdata;

    logic                hist_we;
    logic [HIST_AW-1:0]  hist_waddr;
    logic [CNT_W-1:0]    hist_wdata;
    logic                hist_re;
    logic [HIST_AW-1:0]  hist_raddr;
    logic [CNT_W-1:0]    hist_rdata;

    // Enable register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            enable_reg <= cfg_wr_data;
        end
    end

    lshist_ctrl #(
        .NUM_STAGES  (NUM_STAGES),
        .NUM_BUCKETS (NUM_BUCKETS),
        .STAGE_AW    (STAGE_AW),
        .BKT_AW      (BKT_AW),
        .HIST_DEPTH  (HIST_DEPTH),
        .HIST_AW     (HIST_AW)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .enable     (enable_reg),
        .in_ch      (in_ch),
        .out_ch     (out_ch),
        .stat_we    (stat_we),
        .stat_waddr (stat_waddr),
        .stat_wdata (stat_wdata),
        .stat_re    (stat_re),
        .stat_raddr (stat_raddr),
        .stat_rdata (stat_rdata),
        .hist_we    (hist_we),
        .hist_waddr (hist_waddr),
        .hist_wdata (hist_wdata),
        .hist_re    (hist_re),
        .hist_raddr (hist_raddr),
        .hist_rdata (hist_rdata)
    );

    // Stage entries: count, total, maximum
    lshist_ram #(
        .WIDTH (STAT_W),
        .DEPTH (NUM_STAGES),
        .AW    (STAGE_AW)
    ) u_stat_ram (
        .clk   (clk),
        .we    (stat_we),
        .waddr (stat_waddr),
        .wdata (stat_wdata),
        .re    (stat_re),
        .raddr (stat_raddr),
        .rdata (stat_rdata)
    );

    // Histogram counters, stage-major
    lshist_ram #(
        .WIDTH (CNT_W),
        .DEPTH (HIST_DEPTH),
        .AW    (HIST_AW)
    ) u_hist_ram (
        .clk   (clk),
        .we    (hist_we),
        .waddr (hist_waddr),
        .wdata (hist_wdata),
        .re    (hist_re),
        .raddr (hist_raddr),
        .rdata (hist_rdata)
    );

endmodule

/* src/lshist_ram.sv */
`timescale 1ns / 1ps

module lshist_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 512,
    parameter int AW    = 9
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* src/lshist_ctrl.sv */
`timescale 1ns / 1ps

module lshist_ctrl #(
    parameter int NUM_STAGES  = lshist_pkg::NUM_STAGES_DEF,
    parameter int NUM_BUCKETS = lshist_pkg::NUM_BUCKETS_DEF,
    parameter int STAGE_AW    = 3,
    parameter int BKT_AW      = 6,
    parameter int HIST_DEPTH  = 512,
    parameter int HIST_AW     = 9
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          enable,
    lshist_in_if.sink                     in_ch,
    lshist_out_if.source                  out_ch,
    // statistics memory
    output logic                          stat_we,
    output logic [STAGE_AW-1:0]           stat_waddr,
    output logic [lshist_pkg::STAT_W-1:0] stat_wdata,
    output logic                          stat_re,
    output logic [STAGE_AW-1:0]           stat_raddr,
    input  logic [lshist_pkg::STAT_W-1:0] stat_rdata,
    // histogram memory
    output logic                          hist_we,
    output logic [HIST_AW-1:0]            hist_waddr,
    output logic [lshist_pkg::CNT_W-1:0]  hist_wdata,
    output logic                          hist_re,
    output logic [HIST_AW-1:0]            hist_raddr,
    input  logic [lshist_pkg::CNT_W-1:0]  hist_rdata
);
    import lshist_pkg::*;

    lshist_state_t      state_reg, state_next;
    logic [HIST_AW-1:0] sweep_cnt_reg, sweep_cnt_next;
    logic               out_valid_reg, out_valid_next;

    // Held word
    logic [OP_W-1:0]    op_reg;
    logic [STAGE_W-1:0] stage_reg;
    logic [NS_W-1:0]    ns_reg;
    logic [BKT_W-1:0]   bkt_reg;
    logic               stage_ok_reg;
    logic               bkt_ok_reg;
    logic [HIST_AW-1:0] hist_addr_reg;

    // Result word
    logic [CNT_W-1:0]   count_reg, total_reg, max_reg, hits_reg;

    logic               load_item;
    logic               load_out;
    logic               in_stage_ok;
    logic               in_bkt_ok;
    logic [BKT_W-1:0]   msb;
    logic [BKT_AW-1:0]  rec_bucket;
    logic [BKT_AW-1:0]  bucket_sel;
    logic [HIST_AW-1:0] hist_addr_calc;
    logic               sweep_last;
    logic               sweep_in_stats;
    lshist_stat_t       stat_cur;
    lshist_stat_t       stat_upd;

    assign in_stage_ok = {4'b0, in_ch.stage} < 7'(NUM_STAGES);
    assign in_bkt_ok   = {1'b0, in_ch.bucket_index} < 7'(NUM_BUCKETS);

    // Log2 bucket of the duration, folded into the top bucket
    assign msb        = msb_index(ns_reg);
    assign rec_bucket = ({1'b0, msb} > 7'(NUM_BUCKETS - 1)) ? BKT_AW'(NUM_BUCKETS - 1)
                                                          : BKT_AW'(msb);
    assign bucket_sel = (op_reg == OP_READ) ? BKT_AW'(bkt_reg) : rec_bucket;
    assign hist_addr_calc = (HIST_AW'(STAGE_AW'(stage_reg)) << BKT_AW)
                          | HIST_AW'(bucket_sel);

    // Clearing sweep bounds
    assign sweep_last     = sweep_cnt_reg == HIST_AW'(HIST_DEPTH - 1);
    assign sweep_in_stats = {1'b0, sweep_cnt_reg} < (HIST_AW + 1)'(NUM_STAGES);

    // Stage entry update for a record
    assign stat_cur       = lshist_stat_t'(stat_rdata);
    assign stat_upd.count = stat_cur.count + CNT_W'(1);
    assign stat_upd.total = stat_cur.total + ns_reg;
    assign stat_upd.max   = (ns_reg > stat_cur.max) ? ns_reg : stat_cur.max;

    // Next state and memory control
    always_comb
    begin
        state_next     = state_reg;
        sweep_cnt_next = sweep_cnt_reg;
        out_valid_next = out_valid_reg & ~out_ch.ready;
        load_item      = 1'b0;
        load_out       = 1'b0;
        in_ch.ready    = 1'b0;
        stat_we        = 1'b0;
        stat_waddr     = STAGE_AW'(stage_reg);
        stat_wdata     = STAT_W'(stat_upd);
        stat_re        = 1'b0;
        stat_raddr     = STAGE_AW'(stage_reg);
        hist_we        = 1'b0;
        hist_waddr     = hist_addr_reg;
        hist_wdata     = hist_rdata + CNT_W'(1);
        hist_re        = 1'b0;
        hist_raddr     = hist_addr_calc;

        unique case (state_reg)
            ST_SWEEP:
            begin
                stat_we        = sweep_in_stats;
                stat_waddr     = STAGE_AW'(sweep_cnt_reg);
                stat_wdata     = '0;
                hist_we        = 1'b1;
                hist_waddr     = sweep_cnt_reg;
                hist_wdata     = '0;
                sweep_cnt_next = sweep_cnt_reg + HIST_AW'(1);
                if (sweep_last)
                begin
                    sweep_cnt_next = '0;
                    state_next     = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ch.ready = 1'b1;
                if (in_ch.valid)
                begin
                    load_item = 1'b1;
                    unique case (in_ch.op)
                        OP_RECORD:
                        begin
                            if (enable && in_stage_ok)
                            begin
                                state_next = ST_ISSUE;
                            end
                        end
                        OP_READ:
                        begin
                            state_next = ST_ISSUE;
                        end
                        OP_CLEAR:
                        begin
                            state_next = ST_SWEEP;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_ISSUE:
            begin
                stat_re    = stage_ok_reg;
                hist_re    = stage_ok_reg;
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                if (op_reg == OP_RECORD)
                begin
                    stat_we    = 1'b1;
                    hist_we    = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (!out_valid_reg || out_ch.ready)
                begin
                    load_out       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_SWEEP;
            sweep_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sweep_cnt_reg <= sweep_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (load_item)
        begin
            op_reg       <= in_ch.op;
            stage_reg    <= in_ch.stage;
            ns_reg       <= in_ch.elapsed_ns;
            bkt_reg      <= in_ch.bucket_index;
            stage_ok_reg <= in_stage_ok;
            bkt_ok_reg   <= in_bkt_ok;
        end
        if (state_reg == ST_ISSUE)
        begin
            hist_addr_reg <= hist_addr_calc;
        end
        if (load_out)
        begin
            count_reg <= stage_ok_reg ? stat_cur.count : '0;
            total_reg <= stage_ok_reg ? stat_cur.total : '0;
            max_reg   <= stage_ok_reg ? stat_cur.max : '0;
            hits_reg  <= (stage_ok_reg && bkt_ok_reg) ? hist_rdata : '0;
        end
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.sample_count   = count_reg;
    assign out_ch.duration_total = total_reg;
    assign out_ch.duration_max   = max_reg;
    assign out_ch.bucket_hits    = hits_reg;

endmodule

/* verif/latency_stats_log2_histogram_tb.sv */
`timescale 1ns / 1ps

module latency_stats_log2_histogram_tb;
    import lshist_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int N_STAGES      = NUM_STAGES_DEF;
    localparam int N_BUCKETS     = NUM_BUCKETS_DEF;
    // margin for record words to finish before config writes and at the end
    localparam int SETTLE_CYCLES = 16;
    localparam logic [NS_W-1:0] NS_ALL_ONES = '1;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic [CNT_W-1:0] total;
        logic [CNT_W-1:0] peak;
        logic [CNT_W-1:0] hits;
    } stats_word_t;

    logic clk         = 1'b0;
    logic rst_n       = 1'b0;
    logic cfg_wr_en   = 1'b0;
    logic cfg_wr_data = 1'b0;

    lshist_in_if  in_ch ();
    lshist_out_if out_ch ();

    latency_stats_log2_histogram dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_ch       (in_ch),
        .out_ch      (out_ch)
    );

    // Shadow copy of the statistics stores and the enable register
    logic [CNT_W-1:0] seen_count [N_STAGES];
    logic [CNT_W-1:0] seen_total [N_STAGES];
    logic [CNT_W-1:0] seen_peak  [N_STAGES];
    logic [CNT_W-1:0] seen_hist  [N_STAGES][N_BUCKETS];
    logic             enable_shadow;

    stats_word_t pending_stats[$];
    int          fail_count = 0;
    bit          idle_on    = 1'b1;
    int          stall_left = 0;

    always #2 clk = ~clk;

    function automatic int duration_bucket(input logic [NS_W-1:0] ns);
        logic [NS_W-1:0] d;
        int              b;
        d = ns;
        b = 0;
        while (d > 1 && b < N_BUCKETS - 1)
        begin
            d = d >> 1;
            b++;
        end
        return b;
    endfunction

    task automatic clear_stats_model();
        for (int s = 0; s < N_STAGES; s++)
        begin
            seen_count[s] = '0;
            seen_total[s] = '0;
            seen_peak[s]  = '0;
            for (int b = 0; b < N_BUCKETS; b++)
            begin
                seen_hist[s][b] = '0;
            end
        end
    endtask

    // Update the shadow stores for one accepted word, queue the read answer
    task automatic apply_word(input logic [OP_W-1:0] op, input logic [STAGE_W-1:0] st,
                              input logic [NS_W-1:0] ns, input logic [BKT_W-1:0] bk);
        stats_word_t r;
        case (op)
            OP_RECORD:
            begin
                if (enable_shadow)
                begin
                    seen_count[st] += 1;
                    seen_total[st] += ns;
                    if (ns > seen_peak[st])
                    begin
                        seen_peak[st] = ns;
                    end
                    seen_hist[st][duration_bucket(ns)] += 1;
                end
            end
            OP_READ:
            begin
                r.count = seen_count[st];
                r.total = seen_total[st];
                r.peak  = seen_peak[st];
                r.hits  = seen_hist[st][bk];
                pending_stats.push_back(r);
            end
            OP_CLEAR:
            begin
                clear_stats_model();
            end
            default:
            begin
                // unused op code: nothing happens
            end
        endcase
    endtask

    // Drive one word; valid stays high after acceptance until the next call
    task automatic send_word(input logic [OP_W-1:0] op, input logic [STAGE_W-1:0] st,
                             input logic [NS_W-1:0] ns, input logic [BKT_W-1:0] bk);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 8);
            @(negedge clk);
            in_ch.valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_ch.valid        = 1'b1;
        in_ch.op           = op;
        in_ch.stage        = st;
        in_ch.elapsed_ns   = ns;
        in_ch.bucket_index = bk;
        do
            @(posedge clk);
        while (!in_ch.ready);
        apply_word(op, st, ns, bk);
    endtask

    // Stop sending and wait until every read answer has come back
    task automatic wait_drain();
        @(negedge clk);
        in_ch.valid = 1'b0;
        while (pending_stats.size() != 0)
            @(posedge clk);
    endtask

    // Config write only once the block is idle again (a clearing pass may still run)
    task automatic set_enable(input logic v);
        wait_drain();
        do
            @(posedge clk);
        while (!in_ch.ready);
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = v;
        @(negedge clk);
        cfg_wr_en     = 1'b0;
        enable_shadow = v;
    endtask

    // Durations of random bit length so every bucket gets hits
    function automatic logic [NS_W-1:0] random_duration();
        int              bits;
        logic [NS_W-1:0] v;
        if ($urandom_range(0, 19) == 0)
        begin
            return NS_ALL_ONES;
        end
        bits = $urandom_range(0, NS_W);
        v    = {$urandom, $urandom};
        if (bits == 0)
        begin
            v = '0;
        end
        else if (bits < NS_W)
        begin
            v = (v & ((64'd1 << bits) - 1)) | (64'd1 << (bits - 1));
        end
        return v;
    endfunction

    task automatic send_random_word();
        int               pick;
        logic [OP_W-1:0]  op;
        logic [BKT_W-1:0] bk;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            op = OP_RECORD;
        else if (pick < 93)
            op = OP_READ;
        else if (pick < 95)
            op = OP_CLEAR;
        else
            op = OP_UNUSED;
        // lean toward the populated low buckets half the time
        if ($urandom_range(0, 1) == 0)
            bk = BKT_W'($urandom_range(0, N_BUCKETS - 1));
        else
            bk = BKT_W'($urandom_range(0, 40));
        send_word(op, STAGE_W'($urandom_range(0, N_STAGES - 1)), random_duration(), bk);
    endtask

    // Receiver side: random stall bursts on ready
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            out_ch.ready = 1'b0;
            stall_left--;
        end
        else if (idle_on && $urandom_range(0, 7) == 0)
        begin
            out_ch.ready = 1'b0;
            stall_left   = $urandom_range(0, 7);
        end
        else
        begin
            out_ch.ready = 1'b1;
        end
    end

    task automatic check_field(input string name, input logic [CNT_W-1:0] want,
                               input logic [CNT_W-1:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
            fail_count++;
        end
    endtask

    // Compare each answer word with the oldest expected one
    always @(posedge clk)
    begin
        stats_word_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_stats.size() == 0)
            begin
                $display("%0t: unexpected word: expected none, actual %h %h %h %h", $time,
                         out_ch.sample_count, out_ch.duration_total, out_ch.duration_max,
                         out_ch.bucket_hits);
                fail_count++;
            end
            else
            begin
                want = pending_stats.pop_front();
                check_field("sample_count", want.count, out_ch.sample_count);
                check_field("duration_total", want.total, out_ch.duration_total);
                check_field("duration_max", want.peak, out_ch.duration_max);
                check_field("bucket_hits", want.hits, out_ch.bucket_hits);
            end
        end
    end

    // Records after reset are dropped while disabled; unused op is ignored
    task automatic test_disabled_after_reset();
        send_word(OP_RECORD, 3'd3, 64'd100, 6'd0);
        send_word(OP_READ, 3'd3, '0, 6'd6);
        send_word(OP_UNUSED, 3'd3, 64'd7, 6'd2);
    endtask

    // Bucket edges, the top bucket and wrapping totals
    task automatic test_extremes();
        send_word(OP_RECORD, 3'd0, 64'd0, 6'd0);
        send_word(OP_RECORD, 3'd0, 64'd1, 6'd63);
        send_word(OP_RECORD, 3'd0, 64'd2, 6'd0);
        send_word(OP_RECORD, 3'd0, 64'd3, 6'd0);
        send_word(OP_RECORD, 3'd0, 64'h8000_0000_0000_0000, 6'd0);
        send_word(OP_RECORD, 3'd7, NS_ALL_ONES, 6'd0);
        send_word(OP_RECORD, 3'd7, NS_ALL_ONES, 6'd0);
        send_word(OP_RECORD, 3'd3, 64'h4000_0000_0000_0005, 6'd0);
        send_word(OP_READ, 3'd0, '0, 6'd0);
        send_word(OP_READ, 3'd0, NS_ALL_ONES, 6'd1);
        send_word(OP_READ, 3'd0, '0, 6'd63);
        send_word(OP_READ, 3'd7, '0, 6'd63);
        send_word(OP_READ, 3'd7, '0, 6'd0);
        send_word(OP_READ, 3'd3, '0, 6'd62);
    endtask

    // Reads answer normally and clear still works while disabled
    task automatic test_disabled_ops();
        set_enable(1'b0);
        send_word(OP_RECORD, 3'd7, 64'd5, 6'd0);
        send_word(OP_READ, 3'd7, '0, 6'd63);
        send_word(OP_CLEAR, 3'd7, '0, 6'd0);
        send_word(OP_READ, 3'd7, '0, 6'd63);
    endtask

    task automatic test_unused_op_enabled();
        set_enable(1'b1);
        send_word(OP_UNUSED, 3'd2, 64'd9, 6'd3);
        send_word(OP_READ, 3'd2, '0, 6'd3);
    endtask

    task automatic test_random(input int n);
        for (int i = 0; i < n; i++)
        begin
            send_random_word();
        end
    endtask

    // Sender holds off now and then until all answers are back
    task automatic test_pressure(input int n);
        for (int i = 0; i < n; i++)
        begin
            send_random_word();
            if (i % 25 == 24)
            begin
                wait_drain();
            end
        end
    endtask

    initial
    begin
        in_ch.valid        = 1'b0;
        in_ch.op           = OP_RECORD;
        in_ch.stage        = '0;
        in_ch.elapsed_ns   = '0;
        in_ch.bucket_index = '0;
        out_ch.ready       = 1'b0;
        enable_shadow      = 1'b0;
        clear_stats_model();

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_disabled_after_reset();
        set_enable(1'b1);
        test_extremes();
        test_disabled_ops();
        test_unused_op_enabled();
        test_random(700);
        set_enable(1'b0);
        test_random(150);
        set_enable(1'b1);
        test_pressure(250);
        test_random(500);
        // last stretch runs with no idling on either side
        idle_on = 1'b0;
        test_random(400);
        wait_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Watchdog
    initial
    begin
        #4_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
